>>> hw/rtl/m2ts_pkg.sv
`timescale 1ns / 1ps
package m2ts_pkg;

  localparam int DEF_PACKET_BYTES    = 192;
  localparam int DEF_TIMESTAMP_BYTES = 4;
  localparam int SYNC_RUN            = 8;
  localparam int CNT_W               = 4;

  localparam logic [7:0]       SYNC_VALUE = 8'h47;
  localparam logic [CNT_W-1:0] RUN_LIMIT  = 4'd15;
  localparam logic [2:0]       BSH_MAX    = 3'd7;
  localparam logic [2:0]       BSH_SCORE  = 3'd3;

  typedef enum logic {
    MODE_LOCKED,
    MODE_HUNT
  } mode_t;

  typedef struct packed {
    logic             tag;
    logic [CNT_W-1:0] cnt;
  } run_entry_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       locked;
    logic [7:0] byte_in_packet;
    logic       packet_start;
    logic       sync_found;
    logic       sync_lost;
  } result_t;

  function automatic logic hdr_ok(input logic [7:0] hdr);
    return (hdr[7:6] == 2'b00) && (hdr[5:4] != 2'b00);
  endfunction

endpackage

>>> hw/rtl/m2ts_if.sv
`timescale 1ns / 1ps
interface m2ts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface m2ts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       locked;
  logic [7:0] byte_in_packet;
  logic       packet_start;
  logic       sync_found;
  logic       sync_lost;

  modport source (
    output valid, output byte_out, output locked, output byte_in_packet,
    output packet_start, output sync_found, output sync_lost, input ready
  );
  modport sink (
    input valid, input byte_out, input locked, input byte_in_packet,
    input packet_start, input sync_found, input sync_lost, output ready
  );
endinterface

>>> hw/rtl/m2ts_ram.sv
`timescale 1ns / 1ps
module m2ts_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/m2ts_sync_lock_and_resync.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                   Handshake
// in_bus    in   data_byte                                 valid/ready
// out_bus   out  byte_out, locked, byte_in_packet,         valid/ready
//                packet_start, sync_found, sync_lost
//
// One beat in, one registered beat out; a beat is taken each cycle while not full.
// Run table per beat: read of the next phase, and write of the current when scoring.
// Reset is synchronous: starts locked at packet byte 0, table entries invalid.
// A two-entry output queue holds results; in_bus.ready drops only when both are full.
module m2ts_sync_lock_and_resync import m2ts_pkg::*; #(
  parameter int PACKET_BYTES    = DEF_PACKET_BYTES,
  parameter int TIMESTAMP_BYTES = DEF_TIMESTAMP_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  m2ts_in_if.sink           in_bus,
  m2ts_out_if.source        out_bus
);

  localparam int PW    = $clog2(PACKET_BYTES);
  localparam int HW    = (TIMESTAMP_BYTES >= 3) ? TIMESTAMP_BYTES : 3;
  localparam int NSEED = (TIMESTAMP_BYTES >= 3) ? TIMESTAMP_BYTES - 2 : 0;
  localparam int SW    = (NSEED > 0) ? NSEED : 1;

  localparam logic [PW-1:0] POS_TS     = PW'(TIMESTAMP_BYTES % PACKET_BYTES);
  localparam logic [PW-1:0] POS_LAST   = PW'(PACKET_BYTES - 1);
  localparam logic [PW-1:0] POS_RELOCK = PW'((TIMESTAMP_BYTES + 4) % PACKET_BYTES);
  localparam logic [PW-1:0] BIP_RELOCK = PW'((TIMESTAMP_BYTES + 3) % PACKET_BYTES);
  localparam logic [PW-1:0] PH_LOSS    =
    PW'(((TIMESTAMP_BYTES % PACKET_BYTES) + PACKET_BYTES - 2) % PACKET_BYTES);
  localparam logic [2:0]    BSH_LOSS   = 3'((TIMESTAMP_BYTES > 7) ? 7 : TIMESTAMP_BYTES);

  mode_t             mode_r, mode_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     ph_r, ph_nxt;
  logic [2:0]        bsh_r, bsh_nxt;
  logic              epoch_r, epoch_nxt;
  logic [7:0]        hist_r [HW];
  logic [7:0]        hist_nxt [HW];
  logic [PACKET_BYTES-1:0] vld_r;
  logic [SW-1:0]     seed_r;
  logic [SW-1:0]     seed_vld_r;

  result_t           q_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;

  logic              acc, pop;
  logic [7:0]        data;
  logic [7:0]        rec [HW+1];
  logic [SW-1:0]     seed_new;
  logic [SW-1:0]     seed_sel;
  logic [2:0]        bsh_inc;
  logic              score_en;
  logic              pass;
  logic              lost;
  logic              found;
  logic [CNT_W-1:0]  cnt_old, cnt_new;
  run_entry_t        ram_q;
  run_entry_t        ram_d;
  logic [$bits(run_entry_t)-1:0] ram_rdata;
  result_t           res;

  assign data = in_bus.data_byte;
  assign acc  = in_bus.valid && in_bus.ready;
  assign pop  = out_bus.valid && out_bus.ready;

  assign in_bus.ready  = (cnt_r != 2'd2);
  assign out_bus.valid = (cnt_r != 2'd0);
  assign out_bus.byte_out       = q_r[rd_ptr_r].byte_out;
  assign out_bus.locked         = q_r[rd_ptr_r].locked;
  assign out_bus.byte_in_packet = q_r[rd_ptr_r].byte_in_packet;
  assign out_bus.packet_start   = q_r[rd_ptr_r].packet_start;
  assign out_bus.sync_found     = q_r[rd_ptr_r].sync_found;
  assign out_bus.sync_lost      = q_r[rd_ptr_r].sync_lost;

  always_comb begin
    rec[0] = data;
    for (int i = 1; i <= HW; i++) begin
      rec[i] = hist_r[i-1];
    end
  end

  generate
    if (NSEED > 0) begin : g_seed
      for (genvar k = 0; k < NSEED; k++) begin : g_cand
        assign seed_new[k] = (rec[TIMESTAMP_BYTES-k] == SYNC_VALUE) &&
                             hdr_ok(rec[TIMESTAMP_BYTES-k-3]);
      end
    end else begin : g_noseed
      assign seed_new = '0;
    end
  endgenerate

  m2ts_ram #(
    .WIDTH ($bits(run_entry_t)),
    .DEPTH (PACKET_BYTES)
  ) u_run_ram (
    .clk   (clk),
    .we    (acc && score_en),
    .waddr (ph_r),
    .wdata (ram_d),
    .raddr (ph_nxt),
    .rdata (ram_rdata)
  );

  assign ram_q = run_entry_t'(ram_rdata);
  assign ram_d = '{tag: epoch_r, cnt: cnt_new};

  // score the candidate whose header byte is this beat, and flag a sync loss
  always_comb begin
    bsh_inc  = (bsh_r == BSH_MAX) ? BSH_MAX : bsh_r + 3'd1;
    score_en = (mode_r == MODE_HUNT) && (bsh_inc >= BSH_SCORE);
    pass     = (rec[3] == SYNC_VALUE) && hdr_ok(data);
    seed_sel = '0;
    cnt_old  = (vld_r[ph_r] && (ram_q.tag == epoch_r)) ? ram_q.cnt : '0;
    for (int i = 0; i < SW; i++) begin
      seed_sel[i] = (i < NSEED) && (ph_r == PW'(i)) && seed_vld_r[i];
      if (seed_sel[i]) begin
        cnt_old = {{(CNT_W-1){1'b0}}, seed_r[i]};
      end
    end
    if (!pass) begin
      cnt_new = '0;
    end else if (cnt_old == RUN_LIMIT) begin
      cnt_new = cnt_old;
    end else begin
      cnt_new = cnt_old + 1'b1;
    end
    found = score_en && pass && (cnt_new >= CNT_W'(SYNC_RUN));
    lost  = (mode_r == MODE_LOCKED) && (pos_r == POS_TS) && (data != SYNC_VALUE);
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    ph_nxt    = ph_r;
    bsh_nxt   = bsh_r;
    epoch_nxt = epoch_r;
    hist_nxt  = hist_r;
    if (acc) begin
      hist_nxt[0] = data;
      for (int i = 1; i < HW; i++) begin
        hist_nxt[i] = hist_r[i-1];
      end
      unique case (mode_r)
        MODE_LOCKED: begin
          if (lost) begin
            mode_nxt  = MODE_HUNT;
            epoch_nxt = !epoch_r;
            ph_nxt    = PH_LOSS;
            bsh_nxt   = BSH_LOSS;
            pos_nxt   = '0;
          end else begin
            pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
          end
        end
        MODE_HUNT: begin
          ph_nxt  = (ph_r == POS_LAST) ? '0 : ph_r + 1'b1;
          bsh_nxt = bsh_inc;
          if (found) begin
            mode_nxt = MODE_LOCKED;
            pos_nxt  = POS_RELOCK;
          end
        end
        default: begin
          mode_nxt = MODE_LOCKED;
        end
      endcase
    end
  end

  always_comb begin
    res = '0;
    res.byte_out   = data;
    res.sync_found = found;
    res.sync_lost  = lost;
    unique case (mode_r)
      MODE_LOCKED: begin
        if (!lost) begin
          res.locked         = 1'b1;
          res.byte_in_packet = 8'(pos_r);
          res.packet_start   = (pos_r == '0);
        end
      end
      MODE_HUNT: begin
        if (found) begin
          res.locked         = 1'b1;
          res.byte_in_packet = 8'(BIP_RELOCK);
        end
      end
      default: begin
        res.locked = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_LOCKED;
      pos_r      <= '0;
      ph_r       <= '0;
      bsh_r      <= '0;
      epoch_r    <= 1'b0;
      vld_r      <= '0;
      seed_vld_r <= '0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      cnt_r      <= 2'd0;
      for (int i = 0; i < HW; i++) begin
        hist_r[i] <= 8'd0;
      end
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      ph_r    <= ph_nxt;
      bsh_r   <= bsh_nxt;
      epoch_r <= epoch_nxt;
      hist_r  <= hist_nxt;
      if (acc && score_en) begin
        vld_r[ph_r] <= 1'b1;
        for (int i = 0; i < SW; i++) begin
          if (seed_sel[i]) begin
            seed_vld_r[i] <= 1'b0;
          end
        end
      end
      if (acc && lost) begin
        for (int i = 0; i < SW; i++) begin
          seed_vld_r[i] <= (i < NSEED);
        end
      end
      if (acc) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= 2'(cnt_r + {1'b0, acc} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (acc && lost) begin
      seed_r <= seed_new;
    end
    if (acc) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  a_lost_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && lost) |=> (mode_r == MODE_HUNT && epoch_r != $past(epoch_r)))
    else $error("loss beat did not start a hunt with a fresh epoch");

  a_relock: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && found) |=> (mode_r == MODE_LOCKED && pos_r == POS_RELOCK))
    else $error("relock did not restore packet position");

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (cnt_r == 2'($past(cnt_r) + {1'b0, $past(acc)} - {1'b0, $past(pop)})))
    else $error("output queue count out of step with beats");

  a_ready_reset: assert property (@(posedge clk)
    (!rst_n) |=> (in_bus.ready && !out_bus.valid))
    else $error("queue not empty after reset");

endmodule

>>> sim/m2ts_sync_lock_and_resync_test.sv
`timescale 1ns / 1ps
module m2ts_sync_lock_and_resync_test;
  import m2ts_pkg::*;

  localparam int PKT          = DEF_PACKET_BYTES;
  localparam int TSB          = DEF_TIMESTAMP_BYTES;
  localparam int HIST         = (TSB >= 3) ? TSB + 1 : 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  class align_predictor;
    mode_t            mode;
    int unsigned      pos;
    int unsigned      phase;
    logic [2:0]       since_hunt;
    logic [7:0]       hist[HIST];
    logic [CNT_W-1:0] run_cnt[PKT];
    bit               run_tag[PKT];
    bit               epoch;
    result_t          expected_beats[$];
    int               errors;
    int               beat_no;

    function new();
      mode       = MODE_LOCKED;
      pos        = 0;
      phase      = 0;
      since_hunt = '0;
      epoch      = 1'b0;
      errors     = 0;
      beat_no    = 0;
      foreach (hist[i]) hist[i] = '0;
      foreach (run_cnt[i]) begin
        run_cnt[i] = '0;
        run_tag[i] = 1'b0;
      end
    endfunction

    function bit score(int unsigned ph, logic [7:0] first_b, logic [7:0] hdr_b);
      int unsigned      idx;
      logic [CNT_W-1:0] cnt;
      bit               pass;
      idx  = ph % PKT;
      cnt  = (run_tag[idx] == epoch) ? run_cnt[idx] : '0;
      pass = (first_b == SYNC_VALUE) && (hdr_b[7:6] == 2'b00) && (hdr_b[5:4] != 2'b00);
      if (pass) begin
        if (cnt < RUN_LIMIT) cnt++;
      end else begin
        cnt = '0;
      end
      run_cnt[idx] = cnt;
      run_tag[idx] = epoch;
      return pass && (cnt >= SYNC_RUN);
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      int      k;
      r          = '0;
      r.byte_out = b;
      for (k = HIST - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = b;
      if (mode == MODE_LOCKED) begin
        if (pos == TSB && b != SYNC_VALUE) begin
          r.sync_lost = 1'b1;
          mode        = MODE_HUNT;
          epoch       = ~epoch;
          phase       = TSB % PKT;
          since_hunt  = (TSB > 7) ? BSH_MAX : 3'(TSB);
          pos         = 0;
          for (k = 0; k + 3 <= TSB; k++) void'(score(k, hist[TSB-k], hist[TSB-k-3]));
        end else begin
          r.locked         = 1'b1;
          r.byte_in_packet = 8'(pos);
          r.packet_start   = (pos == 0);
          pos              = (pos + 1) % PKT;
        end
      end else begin
        phase = (phase + 1) % PKT;
        if (since_hunt < BSH_MAX) since_hunt++;
        if (since_hunt >= BSH_SCORE && score((phase + PKT - 3) % PKT, hist[3], b)) begin
          mode             = MODE_LOCKED;
          r.sync_found     = 1'b1;
          r.locked         = 1'b1;
          r.byte_in_packet = 8'((TSB + 3) % PKT);
          pos              = (TSB + 4) % PKT;
        end
      end
      expected_beats.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at result beat %0d: %s", beat_no, what);
      errors++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_beat(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = expected_beats.pop_front();
        check_field("byte_out", got.byte_out, want.byte_out);
        check_field("locked", got.locked, want.locked);
        check_field("byte_in_packet", got.byte_in_packet, want.byte_in_packet);
        check_field("packet_start", got.packet_start, want.packet_start);
        check_field("sync_found", got.sync_found, want.sync_found);
        check_field("sync_lost", got.sync_lost, want.sync_lost);
      end
      beat_no++;
    endtask

    function int pending();
      return expected_beats.size();
    endfunction

    task close_out();
      if (expected_beats.size() != 0)
        report($sformatf("%0d expected beats never arrived", expected_beats.size()));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   calm  = 1'b0;

  align_predictor sb;

  m2ts_in_if  in_bus();
  m2ts_out_if out_bus();

  m2ts_sync_lock_and_resync u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic send_packet();
    int         i;
    logic [7:0] b;
    for (i = 0; i < PKT; i++) begin
      b = 8'($urandom);
      if (i == TSB) b = SYNC_VALUE;
      if (i == TSB + 3) b = {2'b00, 2'($urandom_range(1, 3)), 4'($urandom)};
      send_byte(b);
    end
  endtask

  initial begin : calm_toggle
    forever begin
      repeat ($urandom_range(150, 400)) @(posedge clk);
      calm = ~calm;
    end
  end

  initial begin : result_sink
    int stall;
    stall         = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.byte_out       = out_bus.byte_out;
      got.locked         = out_bus.locked;
      got.byte_in_packet = out_bus.byte_in_packet;
      got.packet_start   = out_bus.packet_start;
      got.sync_found     = out_bus.sync_found;
      got.sync_lost      = out_bus.sync_lost;
      sb.check_beat(got);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] directed[$];
    logic [7:0] b;
    int         k;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // locked start, loss on the first sync byte, then hunt over edge values
    directed = '{8'h47, 8'hFF, 8'h00, 8'h10, 8'h00, 8'hFF, 8'h80, 8'h47, 8'h01,
                 8'h7F, 8'h30, 8'h47, 8'hC0, 8'h20, 8'h47, 8'hAA, 8'h55, 8'h3F,
                 8'h40, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);

    // shift alignment, relock on a clean run, pass one locked check, then lose it
    repeat ($urandom_range(1, 100)) send_byte(8'($urandom));
    repeat (SYNC_RUN + 1) send_packet();
    for (k = 0; k <= TSB; k++) begin
      b = 8'($urandom);
      if (k == TSB) begin
        do b = 8'($urandom); while (b == SYNC_VALUE);
      end
      send_byte(b);
    end
    repeat ($urandom_range(5, 20)) send_byte(8'($urandom));
    in_bus.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
